// ===== rtl/wfa_pkg.sv =====
// shared types and constants for the worst-fit block allocator
`default_nettype none

package wfa_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;

   localparam int FUNC_W   = 1;
   localparam int BLKIDX_W = 4;
   localparam int FSIZE_W  = 16;
   localparam int COUNT_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [BLKIDX_W-1:0] block_index;
      logic [FSIZE_W-1:0]  block_size;
      logic [FSIZE_W-1:0]  request_size;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [BLKIDX_W-1:0] chosen_block;
      logic [FSIZE_W-1:0]  leftover;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/wfa_cell.sv =====
// one block of the allocator: stored size, used flag and one stage of the search probe
`default_nettype none

module wfa_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 4,
   parameter int SIZE_BITS  = wfa_pkg::SIZE_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [wfa_pkg::COUNT_W-1:0] block_count,
   input  wire logic                        load_en,
   input  wire logic [IDX_W-1:0]            load_idx,
   input  wire logic [SIZE_BITS-1:0]        load_size,
   input  wire logic                        mark_en,
   input  wire logic [IDX_W-1:0]            mark_idx,
   input  wire logic                        in_valid,
   input  wire logic [SIZE_BITS-1:0]        in_req,
   input  wire logic                        in_found,
   input  wire logic [IDX_W-1:0]            in_idx,
   input  wire logic [SIZE_BITS-1:0]        in_left,
   output logic                             out_valid,
   output logic [SIZE_BITS-1:0]             out_req,
   output logic                             out_found,
   output logic [IDX_W-1:0]                 out_idx,
   output logic [SIZE_BITS-1:0]             out_left
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [SIZE_BITS-1:0] size_ff;
   logic                 used_ff, used_in;
   logic                 valid_ff;
   logic [SIZE_BITS-1:0] req_ff, left_ff, left_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   logic                 active;
   logic                 fits;
   logic [SIZE_BITS-1:0] my_left;
   logic                 take;

   // block takes part only below the configured count
   assign active  = 32'(CELL_INDEX) < 32'(block_count);
   assign fits    = (size_ff >= in_req);
   assign my_left = size_ff - in_req;
   assign take    = active && !used_ff && fits && (!in_found || (my_left > in_left));

   always_comb begin
      used_in = used_ff;
      if (load_en && (load_idx == MY_IDX)) begin
         used_in = 1'b0;
      end else if (mark_en && (mark_idx == MY_IDX)) begin
         used_in = 1'b1;
      end
      found_in = in_found;
      idx_in   = in_idx;
      left_in  = in_left;
      if (take) begin
         found_in = 1'b1;
         idx_in   = MY_IDX;
         left_in  = my_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && (load_idx == MY_IDX)) begin
         size_ff <= load_size;
      end
      req_ff   <= in_req;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      left_ff  <= left_in;
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;
   assign out_found = found_ff;
   assign out_idx   = idx_ff;
   assign out_left  = left_ff;

endmodule

`default_nettype wire

// ===== rtl/worst_fit_block_allocator.sv =====
// worst-fit block allocator: request control and the chain of block cells
// a load request is taken and gives no response
// an allocation probe walks the cell chain one block per cycle; its response is
// registered once the probe leaves the last cell
// no new request is taken while an allocation probe is in the cell chain
// synchronous active-high reset clears used flags, block_count and all control;
// stored sizes are not cleared
`default_nettype none

module worst_fit_block_allocator #(
   parameter int NUM_BLOCKS = wfa_pkg::NUM_BLOCKS,
   parameter int SIZE_BITS  = wfa_pkg::SIZE_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire wfa_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output wfa_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [wfa_pkg::COUNT_W-1:0] csr_data
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [wfa_pkg::COUNT_W-1:0] count_ff;
   logic                        inj_valid_ff;
   logic [SIZE_BITS-1:0]        inj_req_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   wfa_pkg::rsp_type            rsp_data_ff;

   logic                 req_fire;
   logic                 alloc_fire;
   logic                 load_en;
   logic [IDX_W-1:0]     load_idx;
   logic [SIZE_BITS-1:0] load_size;
   logic                 mark_en;

   logic                 chain_valid [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0] chain_req   [NUM_BLOCKS+1];
   logic                 chain_found [NUM_BLOCKS+1];
   logic [IDX_W-1:0]     chain_idx   [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0] chain_left  [NUM_BLOCKS+1];

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign alloc_fire = req_fire && (req_data.func == wfa_pkg::FUNC_ALLOC);
   assign load_en    = req_fire && (req_data.func == wfa_pkg::FUNC_LOAD) &&
                       (32'(req_data.block_index) < 32'(NUM_BLOCKS));
   assign load_idx   = IDX_W'(req_data.block_index);
   assign load_size  = SIZE_BITS'(req_data.block_size);

   // probe head: nothing found yet
   assign chain_valid[0] = inj_valid_ff;
   assign chain_req[0]   = inj_req_ff;
   assign chain_found[0] = 1'b0;
   assign chain_idx[0]   = '0;
   assign chain_left[0]  = '0;

   for (genvar gi = 0; gi < NUM_BLOCKS; gi++) begin : g_cell
      wfa_cell #(
         .CELL_INDEX (gi),
         .IDX_W      (IDX_W),
         .SIZE_BITS  (SIZE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .block_count (count_ff),
         .load_en     (load_en),
         .load_idx    (load_idx),
         .load_size   (load_size),
         .mark_en     (mark_en),
         .mark_idx    (chain_idx[NUM_BLOCKS]),
         .in_valid    (chain_valid[gi]),
         .in_req      (chain_req[gi]),
         .in_found    (chain_found[gi]),
         .in_idx      (chain_idx[gi]),
         .in_left     (chain_left[gi]),
         .out_valid   (chain_valid[gi+1]),
         .out_req     (chain_req[gi+1]),
         .out_found   (chain_found[gi+1]),
         .out_idx     (chain_idx[gi+1]),
         .out_left    (chain_left[gi+1])
      );
   end

   // winner is marked used as the probe leaves the chain
   assign mark_en = chain_valid[NUM_BLOCKS] && chain_found[NUM_BLOCKS];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (alloc_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_valid[NUM_BLOCKS]) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (chain_valid[NUM_BLOCKS]) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         inj_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inj_valid_ff <= alloc_fire;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (alloc_fire) begin
         inj_req_ff <= SIZE_BITS'(req_data.request_size);
      end
      if (chain_valid[NUM_BLOCKS]) begin
         rsp_data_ff.granted <= chain_found[NUM_BLOCKS];
         if (chain_found[NUM_BLOCKS]) begin
            rsp_data_ff.chosen_block <= wfa_pkg::BLKIDX_W'(chain_idx[NUM_BLOCKS]);
            rsp_data_ff.leftover     <= wfa_pkg::FSIZE_W'(chain_left[NUM_BLOCKS]);
         end else begin
            rsp_data_ff.chosen_block <= '0;
            rsp_data_ff.leftover     <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/wfa_checker.sv =====
// port-level checks for the worst-fit block allocator, bound to the top level
`default_nettype none

module wfa_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire wfa_pkg::req_type            req_data,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire wfa_pkg::rsp_type            rsp_data
);

   // a pending response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a refused allocation reports zero block and zero leftover
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |->
         (rsp_data.chosen_block == '0) && (rsp_data.leftover == '0))
      else $error("refused allocation carries nonzero fields");

   // an accepted allocation blocks further requests while the probe runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == wfa_pkg::FUNC_ALLOC) |=> !req_ready)
      else $error("request accepted during allocation search");

   // a fresh response never appears right after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response appeared too early");

endmodule

bind worst_fit_block_allocator wfa_checker u_wfa_checker (.*);

`default_nettype wire

// ===== tb/worst_fit_block_allocator_tb.sv =====
// testbench for the worst-fit block allocator: directed table, then random phases
`timescale 1ns / 1ps

module worst_fit_block_allocator_tb;

   localparam int SETTLE_CYCLES  = wfa_pkg::NUM_BLOCKS + 8;
   localparam int STALL_LIMIT    = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 110;

   localparam wfa_pkg::rsp_type NO_RSP = '0;
   localparam logic [wfa_pkg::FSIZE_W-1:0] SEED_SIZES [wfa_pkg::NUM_BLOCKS] = '{
      16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h0400, 16'h0500, 16'h0600, 16'h0700,
      16'h0800, 16'h0900, 16'h0A00, 16'h0B00, 16'h0C00, 16'h0D00, 16'h0E00, 16'h0F00};

   typedef enum logic [1:0] {ROW_LOAD, ROW_ALLOC, ROW_COUNT} row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      logic [wfa_pkg::BLKIDX_W-1:0] block_index;
      logic [wfa_pkg::FSIZE_W-1:0]  block_size;
      logic [wfa_pkg::FSIZE_W-1:0]  request_size;
      logic [wfa_pkg::COUNT_W-1:0]  count;
      logic                         typed;
      wfa_pkg::rsp_type             typed_rsp;
   } plan_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   wfa_pkg::req_type            req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   wfa_pkg::rsp_type            rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [wfa_pkg::COUNT_W-1:0] csr_data = '0;

   // mirror of the allocator state
   logic [wfa_pkg::FSIZE_W-1:0] size_mirror [wfa_pkg::NUM_BLOCKS];
   bit                          used_mirror [wfa_pkg::NUM_BLOCKS];
   logic [wfa_pkg::COUNT_W-1:0] count_mirror = '0;

   wfa_pkg::rsp_type            pending_grants [$];
   wfa_pkg::rsp_type            grant_due;
   int                          mismatches = 0;
   bit                          steady_phase = 1'b0;
   bit                          holdoff_pending = 1'b0;

   worst_fit_block_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // returns 1 when the request yields a grant or refusal
   function automatic bit apply_to_block_mirror(input wfa_pkg::req_type item,
                                                output wfa_pkg::rsp_type outcome);
      int                           span;
      bit                           found;
      logic [wfa_pkg::BLKIDX_W-1:0] best_block;
      logic [wfa_pkg::FSIZE_W-1:0]  best_left;
      outcome = '0;
      if (item.func == wfa_pkg::FUNC_LOAD) begin
         size_mirror[item.block_index] = item.block_size;
         used_mirror[item.block_index] = 1'b0;
         return 1'b0;
      end
      span = (count_mirror > wfa_pkg::NUM_BLOCKS) ? wfa_pkg::NUM_BLOCKS : int'(count_mirror);
      found = 1'b0;
      best_block = '0;
      best_left = '0;
      for (int i = 0; i < span; i++) begin
         if (!used_mirror[i] && size_mirror[i] >= item.request_size) begin
            if (!found || size_mirror[i] - item.request_size > best_left) begin
               found = 1'b1;
               best_block = wfa_pkg::BLKIDX_W'(i);
               best_left = size_mirror[i] - item.request_size;
            end
         end
      end
      if (found) begin
         used_mirror[best_block] = 1'b1;
         outcome.granted = 1'b1;
         outcome.chosen_block = best_block;
         outcome.leftover = best_left;
      end
      return 1'b1;
   endfunction

   // mostly well-formed traffic: requests aimed at stored sizes, loads kept below the count
   function automatic wfa_pkg::req_type random_request(input bit alloc_only);
      wfa_pkg::req_type             item;
      int                           span;
      logic [wfa_pkg::BLKIDX_W-1:0] peek;
      item.func = wfa_pkg::FUNC_LOAD;
      item.block_index = wfa_pkg::BLKIDX_W'($urandom);
      item.block_size = wfa_pkg::FSIZE_W'($urandom);
      item.request_size = wfa_pkg::FSIZE_W'($urandom);
      span = (count_mirror > wfa_pkg::NUM_BLOCKS) ? wfa_pkg::NUM_BLOCKS : int'(count_mirror);
      if (!alloc_only && $urandom_range(0, 99) < 40) begin
         if (span > 0 && $urandom_range(0, 3) != 0)
            item.block_index = wfa_pkg::BLKIDX_W'($urandom_range(0, span - 1));
         case ($urandom_range(0, 3))
            0: item.block_size = wfa_pkg::FSIZE_W'($urandom_range(0, 15)) << 4;
            1: item.block_size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: ;
         endcase
      end else begin
         item.func = wfa_pkg::FUNC_ALLOC;
         peek = wfa_pkg::BLKIDX_W'($urandom_range(0, wfa_pkg::NUM_BLOCKS - 1));
         case ($urandom_range(0, 4))
            0: item.request_size = size_mirror[peek];
            1: item.request_size = size_mirror[peek] >> $urandom_range(1, 4);
            2: item.request_size = wfa_pkg::FSIZE_W'($urandom_range(0, 255));
            3: item.request_size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: ;
         endcase
      end
      return item;
   endfunction

   task automatic push_request(input wfa_pkg::req_type item, input logic typed,
                               input wfa_pkg::rsp_type typed_rsp);
      wfa_pkg::rsp_type outcome;
      while (!steady_phase && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (apply_to_block_mirror(item, outcome))
         pending_grants.push_back(typed ? typed_rsp : outcome);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      // loads give nothing back, so let the scan chain settle too
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_block_count(input logic [wfa_pkg::COUNT_W-1:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      count_mirror = value;
   endtask

   function automatic void check_field(input string label, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual %h",
                     $time, rsp_data);
            mismatches++;
         end else begin
            grant_due = pending_grants.pop_front();
            check_field("granted", grant_due.granted, rsp_data.granted);
            check_field("chosen_block", grant_due.chosen_block, rsp_data.chosen_block);
            check_field("leftover", grant_due.leftover, rsp_data.leftover);
         end
      end
   end

   initial begin : receiver
      int holdoff_left;
      holdoff_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_phase || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      plan_row_type     plan_table [$];
      plan_row_type     row;
      wfa_pkg::req_type item;
      foreach (size_mirror[i]) begin
         size_mirror[i] = '0;
         used_mirror[i] = 1'b0;
      end

      // nothing takes part right after reset
      plan_table.push_back('{ROW_ALLOC, 4'h0, 16'h0000, 16'hFFFF, 5'd0, 1'b1, NO_RSP});
      for (int i = 0; i < wfa_pkg::NUM_BLOCKS; i++)
         plan_table.push_back('{ROW_LOAD, 4'(i), SEED_SIZES[i], 16'hA5A5, 5'd0, 1'b0, NO_RSP});
      plan_table.push_back('{ROW_COUNT, 4'h0, 16'h0000, 16'h0000, 5'd16, 1'b0, NO_RSP});
      plan_table.push_back('{ROW_ALLOC, 4'h0, 16'h0000, 16'h0000, 5'd0, 1'b1,
                             {1'b1, 4'h1, 16'hFFFF}});
      plan_table.push_back('{ROW_ALLOC, 4'hF, 16'hFFFF, 16'hFFFF, 5'd0, 1'b1, NO_RSP});
      // equal sizes in blocks 2 and 3
      plan_table.push_back('{ROW_ALLOC, 4'hF, 16'hFFFF, 16'h0100, 5'd0, 1'b0, NO_RSP});
      plan_table.push_back('{ROW_LOAD, 4'h1, 16'hFFFF, 16'hFFFF, 5'd0, 1'b0, NO_RSP});
      plan_table.push_back('{ROW_ALLOC, 4'h0, 16'h0000, 16'hFFFF, 5'd0, 1'b1,
                             {1'b1, 4'h1, 16'h0000}});
      // count above the table size
      plan_table.push_back('{ROW_COUNT, 4'h0, 16'h0000, 16'h0000, 5'd31, 1'b0, NO_RSP});
      plan_table.push_back('{ROW_ALLOC, 4'h0, 16'h0000, 16'h0001, 5'd0, 1'b0, NO_RSP});
      // a load past the count still lands in the table
      plan_table.push_back('{ROW_COUNT, 4'h0, 16'h0000, 16'h0000, 5'd3, 1'b0, NO_RSP});
      plan_table.push_back('{ROW_LOAD, 4'hA, 16'hFFFF, 16'h0000, 5'd0, 1'b0, NO_RSP});
      plan_table.push_back('{ROW_ALLOC, 4'h0, 16'h0000, 16'h0000, 5'd0, 1'b0, NO_RSP});

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (plan_table[n]) begin
         row = plan_table[n];
         case (row.kind)
            ROW_COUNT: write_block_count(row.count);
            ROW_LOAD, ROW_ALLOC: begin
               item.func = (row.kind == ROW_LOAD) ? wfa_pkg::FUNC_LOAD : wfa_pkg::FUNC_ALLOC;
               item.block_index = row.block_index;
               item.block_size = row.block_size;
               item.request_size = row.request_size;
               push_request(item, row.typed, row.typed_rsp);
            end
            default: ;
         endcase
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: write_block_count(5'd16);
            1: write_block_count(5'd0);
            2: write_block_count(5'd31);
            3: write_block_count(5'd1);
            default: write_block_count(wfa_pkg::COUNT_W'($urandom_range(2, 20)));
         endcase
         steady_phase = (phase == 4);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // receiver backs off while a burst of allocations piles up
            if (phase == 5 && k == 10)
               holdoff_pending = 1'b1;
            if (phase == 7 && k == 55)
               drain_responses();
            push_request(random_request(phase == 5 && k >= 10 && k < 40), 1'b0, NO_RSP);
         end
      end
      steady_phase = 1'b0;

      drain_responses();
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wfa_pkg.sv
rtl/wfa_cell.sv
rtl/worst_fit_block_allocator.sv
rtl/wfa_checker.sv
tb/worst_fit_block_allocator_tb.sv
